[src/mm2_pkg.sv]
// shared types, constants and the microcode table of the murmur2 stream hash
package mm2_pkg;

   // hash constants
   localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
   localparam int unsigned MIX_SHIFT   = 24;
   localparam int unsigned FIN_SHIFT_A = 13;
   localparam int unsigned FIN_SHIFT_B = 15;

   localparam logic [2:0]  FULL_COUNT  = 3'd4;

   // program step addresses
   typedef logic [2:0] step_type;
   localparam step_type STEP_WAIT = 3'd0;
   localparam step_type STEP_K1   = 3'd1;
   localparam step_type STEP_K2   = 3'd2;
   localparam step_type STEP_HMIX = 3'd3;
   localparam step_type STEP_FIN1 = 3'd4;
   localparam step_type STEP_FIN2 = 3'd5;
   localparam step_type STEP_TAIL = 3'd6;
   localparam step_type STEP_TMUL = 3'd7;

   // multiplier operand
   typedef enum logic [1:0] {
      SRC_WORD,
      SRC_KMIX,
      SRC_H,
      SRC_HFIN
   } mul_src_type;

   // where the product goes
   typedef enum logic [1:0] {
      DST_NONE,
      DST_K,
      DST_H,
      DST_HK
   } mul_dst_type;

   // condition that keeps the step counter in place
   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_NOGO,
      HOLD_OUT_BUSY
   } hold_type;

   // condition for taking the jump target
   typedef enum logic [2:0] {
      JMP_NONE,
      JMP_ALWAYS,
      JMP_TAIL,
      JMP_NOT_LAST,
      JMP_ZERO_COUNT
   } jump_type;

   // one microcode word
   typedef struct packed {
      logic        accept;
      mul_src_type mul_src;
      mul_dst_type mul_dst;
      logic        tail_xor;
      logic        out_load;
      hold_type    hold;
      jump_type    jump;
      step_type    target;
   } ucode_type;

   // sequencer to datapath controls
   typedef struct packed {
      logic        accept;
      mul_src_type mul_src;
      mul_dst_type mul_dst;
      logic        tail_xor;
      logic        out_load;
   } ctrl_type;

   // datapath to sequencer flags
   typedef struct packed {
      logic go;
      logic tail;
      logic last;
      logic zero_count;
      logic out_busy;
   } status_type;

   // microcode table
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      begin
         w = '{accept: 1'b0, mul_src: SRC_WORD, mul_dst: DST_NONE, tail_xor: 1'b0,
               out_load: 1'b0, hold: HOLD_NONE, jump: JMP_NONE, target: STEP_WAIT};
         case (step)
            STEP_WAIT: begin
               w.accept = 1'b1;
               w.hold   = HOLD_NOGO;
            end
            STEP_K1: begin
               w.mul_src = SRC_WORD;
               w.mul_dst = DST_K;
               w.jump    = JMP_TAIL;
               w.target  = STEP_TAIL;
            end
            STEP_K2: begin
               w.mul_src = SRC_KMIX;
               w.mul_dst = DST_K;
            end
            STEP_HMIX: begin
               w.mul_src = SRC_H;
               w.mul_dst = DST_HK;
               w.jump    = JMP_NOT_LAST;
               w.target  = STEP_WAIT;
            end
            STEP_FIN1: begin
               w.mul_src = SRC_HFIN;
               w.mul_dst = DST_H;
            end
            STEP_FIN2: begin
               w.out_load = 1'b1;
               w.hold     = HOLD_OUT_BUSY;
               w.jump     = JMP_ALWAYS;
               w.target   = STEP_WAIT;
            end
            STEP_TAIL: begin
               w.tail_xor = 1'b1;
               w.jump     = JMP_ZERO_COUNT;
               w.target   = STEP_FIN1;
            end
            STEP_TMUL: begin
               w.mul_src = SRC_H;
               w.mul_dst = DST_H;
               w.jump    = JMP_ALWAYS;
               w.target  = STEP_FIN1;
            end
            default: begin
               w.jump   = JMP_ALWAYS;
               w.target = STEP_WAIT;
            end
         endcase
         return w;
      end
   endfunction

endpackage

[src/mm2_seq.sv]
// step counter and microcode sequencer of the murmur2 stream hash
module mm2_seq (
   input  logic               clock,
   input  logic               reset,
   input  mm2_pkg::status_type status,
   output mm2_pkg::ctrl_type   ctrl
);

   mm2_pkg::step_type  step_ff;
   mm2_pkg::step_type  step_in;
   mm2_pkg::ucode_type uword;
   logic               hold;
   logic               take;

   // fetch the control word of this step
   assign uword = mm2_pkg::ucode_rom(step_ff);

   // hold and jump conditions
   always_comb begin
      case (uword.hold)
         mm2_pkg::HOLD_NOGO:     hold = !status.go;
         mm2_pkg::HOLD_OUT_BUSY: hold = status.out_busy;
         default:                hold = 1'b0;
      endcase
      case (uword.jump)
         mm2_pkg::JMP_ALWAYS:     take = 1'b1;
         mm2_pkg::JMP_TAIL:       take = status.tail;
         mm2_pkg::JMP_NOT_LAST:   take = !status.last;
         mm2_pkg::JMP_ZERO_COUNT: take = status.zero_count;
         default:                 take = 1'b0;
      endcase
      if (hold) begin
         step_in = step_ff;
      end else if (take) begin
         step_in = uword.target;
      end else begin
         step_in = step_ff + 3'd1;
      end
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= mm2_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   // controls to the datapath, result load only when the slot is free
   always_comb begin
      ctrl.accept   = uword.accept;
      ctrl.mul_src  = uword.mul_src;
      ctrl.mul_dst  = uword.mul_dst;
      ctrl.tail_xor = uword.tail_xor;
      ctrl.out_load = uword.out_load && !status.out_busy;
   end

endmodule

[src/mm2_datapath.sv]
// registers, shared multiplier and result register of the murmur2 stream hash
module mm2_datapath (
   input  logic                clock,
   input  logic                reset,
   input  mm2_pkg::ctrl_type   ctrl,
   output mm2_pkg::status_type status,
   // seed write
   input  logic                csr_write,
   input  logic [31:0]         csr_seed,
   // request fields
   input  logic                req_valid,
   input  logic [31:0]         data_word,
   input  logic [2:0]          valid_bytes,
   input  logic                first_word,
   input  logic                last_word,
   input  logic [31:0]         total_length,
   // result
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [31:0]         hash_value
);

   logic [31:0] seed_ff;
   logic [31:0] h_ff;
   logic [31:0] h_in;
   logic [31:0] k_ff;
   logic [31:0] k_in;
   logic [31:0] word_ff;
   logic [2:0]  count_ff;
   logic        last_ff;
   logic        in_msg_ff;
   logic        in_msg_in;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        accepted;
   logic [2:0]  count_clamp;
   logic [31:0] mul_op;
   logic [31:0] mul_res;
   logic [31:0] tail_mask;

   assign accepted    = ctrl.accept && req_valid;
   assign count_clamp = (valid_bytes > mm2_pkg::FULL_COUNT) ? mm2_pkg::FULL_COUNT
                                                            : valid_bytes;

   // shared multiplier by the mixing constant
   always_comb begin
      case (ctrl.mul_src)
         mm2_pkg::SRC_WORD: mul_op = word_ff;
         mm2_pkg::SRC_KMIX: mul_op = k_ff ^ (k_ff >> mm2_pkg::MIX_SHIFT);
         mm2_pkg::SRC_H:    mul_op = h_ff;
         mm2_pkg::SRC_HFIN: mul_op = h_ff ^ (h_ff >> mm2_pkg::FIN_SHIFT_A);
         default:           mul_op = word_ff;
      endcase
   end
   assign mul_res = mul_op * mm2_pkg::MIX_MUL;

   // tail bytes that take part
   always_comb begin
      case (count_ff)
         3'd1:    tail_mask = 32'h0000_00ff;
         3'd2:    tail_mask = 32'h0000_ffff;
         3'd3:    tail_mask = 32'h00ff_ffff;
         default: tail_mask = '0;
      endcase
   end

   // next running hash and mixed word
   always_comb begin
      h_in      = h_ff;
      k_in      = k_ff;
      in_msg_in = in_msg_ff;
      if (accepted && first_word) begin
         h_in      = seed_ff ^ total_length;
         in_msg_in = 1'b1;
      end
      case (ctrl.mul_dst)
         mm2_pkg::DST_K:  k_in = mul_res;
         mm2_pkg::DST_H:  h_in = mul_res;
         mm2_pkg::DST_HK: h_in = mul_res ^ k_ff;
         default:         ;
      endcase
      if (ctrl.tail_xor) begin
         h_in = h_ff ^ (word_ff & tail_mask);
      end
      if (ctrl.out_load) begin
         in_msg_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            seed_ff <= csr_seed;
         end
         in_msg_ff <= in_msg_in;
         if (ctrl.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      h_ff <= h_in;
      k_ff <= k_in;
      if (accepted) begin
         word_ff  <= data_word;
         count_ff <= count_clamp;
         last_ff  <= last_word;
      end
      if (ctrl.out_load) begin
         rsp_data_ff <= h_ff ^ (h_ff >> mm2_pkg::FIN_SHIFT_B);
      end
   end

   // flags to the sequencer
   always_comb begin
      status.go         = accepted && (first_word || in_msg_ff);
      status.tail       = (count_ff != mm2_pkg::FULL_COUNT);
      status.last       = last_ff;
      status.zero_count = (count_ff == 3'd0);
      status.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign hash_value = rsp_data_ff;

endmodule

[src/murmur2_stream_hash_top.sv]
// Streaming 32-bit MurmurHash2. A message arrives as little-endian 32-bit
// words; the word marked by tuser starts it (hash = seed xor total length),
// tlast or a word with fewer than four valid bytes ends it, and the finalized
// hash comes out as one response. A small microcode program steps one shared
// 32x32 multiplier: a full word takes three dependent multiplies plus the
// accept step; a last word then runs the finalization steps, after a tail of
// one to three bytes, if any, is xored in and multiplied, and a finished hash
// waits while the response channel stalls. A word that arrives while no
// message is open and is not a first word is dropped. The user must write the
// seed through the csr channel only while no message is in flight; the block does not enforce it.
module murmur2_stream_hash_top (
   input  logic        clock,
   input  logic        reset,
   // seed register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,
   // message words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // data_word[31:0], valid_bytes[34:32],
                                   // total_length[66:35], zero fill
   input  logic        req_tuser,  // first_word
   input  logic        req_tlast,  // last_word
   // hash responses
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // hash_value[31:0]
);

   mm2_pkg::ctrl_type   ctrl;
   mm2_pkg::status_type status;

   assign csr_ready  = 1'b1;
   assign req_tready = ctrl.accept;

   // microcode sequencer
   mm2_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // hash datapath
   mm2_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .status       (status),
      .csr_write    (csr_valid && csr_ready),
      .csr_seed     (csr_data),
      .req_valid    (req_tvalid),
      .data_word    (req_tdata[31:0]),
      .valid_bytes  (req_tdata[34:32]),
      .first_word   (req_tuser),
      .last_word    (req_tlast),
      .total_length (req_tdata[66:35]),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .hash_value   (rsp_tdata)
   );

endmodule

[dv/testbench.sv]
// self-checking testbench for the murmur2 stream hash top level
`timescale 1ns / 1ps

module testbench;

   // running predictor of the streamed hash and the queue of hashes still owed
   class hash_scoreboard;
      logic [31:0] seed;
      logic [31:0] running;
      bit          open;
      logic [31:0] owed_hashes[$];
      int          fail_count;

      function new();
         seed       = '0;
         running    = '0;
         open       = 1'b0;
         fail_count = 0;
      endfunction

      function void set_seed(logic [31:0] value);
         seed = value;
      endfunction

      function int pending();
         return owed_hashes.size();
      endfunction

      // xor-shift, multiply, xor-shift
      function logic [31:0] final_mix(logic [31:0] h);
         logic [31:0] m;
         m = h ^ (h >> mm2_pkg::FIN_SHIFT_A);
         m = m * mm2_pkg::MIX_MUL;
         return m ^ (m >> mm2_pkg::FIN_SHIFT_B);
      endfunction

      // fold one accepted request into the hash, returns 0 if the block drops it
      function bit note_request(logic [31:0] word, logic [2:0] count, bit first,
                                bit last, logic [31:0] length);
         logic [31:0] k;
         logic [31:0] h;
         bit          ends;
         ends = last;
         if (count > mm2_pkg::FULL_COUNT)
            count = mm2_pkg::FULL_COUNT;
         if (first) begin
            running = seed ^ length;
            open    = 1'b1;
         end else if (!open) begin
            return 1'b0;
         end
         h = running;
         if (count == mm2_pkg::FULL_COUNT) begin
            k = word * mm2_pkg::MIX_MUL;
            k = k ^ (k >> mm2_pkg::MIX_SHIFT);
            k = k * mm2_pkg::MIX_MUL;
            h = h * mm2_pkg::MIX_MUL;
            h = h ^ k;
         end else begin
            // tail bytes, a short word always closes the message
            if (count >= 3'd3)
               h = h ^ {8'h00, word[23:16], 16'h0000};
            if (count >= 3'd2)
               h = h ^ {16'h0000, word[15:8], 8'h00};
            if (count >= 3'd1) begin
               h = h ^ {24'h000000, word[7:0]};
               h = h * mm2_pkg::MIX_MUL;
            end
            ends = 1'b1;
         end
         running = h;
         if (ends) begin
            owed_hashes.push_back(final_mix(h));
            open = 1'b0;
         end
         return 1'b1;
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         fail_count++;
      endtask

      task check_response(logic [31:0] got);
         logic [31:0] want;
         if (owed_hashes.size() == 0) begin
            report($sformatf("hash %h with no message pending", got));
         end else begin
            want = owed_hashes.pop_front();
            if (got !== want)
               report($sformatf("hash_value got %h expected %h", got, want));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   hash_scoreboard sb = new();

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_asks = 0;
   int words_used = 0;

   murmur2_stream_hash_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // response side: check, then pick next tready (long hold-off on request)
   int hold_left = 0;
   int hold_done = 0;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_asks != hold_done) begin
         hold_done = hold_asks;
         hold_left = 300;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // one request word, with a random gap in front of it
   task send_word(logic [31:0] word, logic [2:0] count, bit first, bit last,
                  logic [31:0] length);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, length, count, word};
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      words_used += sb.note_request(word, count, first, last, length);
   endtask

   function logic [31:0] rand_word();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // mostly 4, now and then an oversized count
   function logic [2:0] full_count();
      if ($urandom_range(9) == 0)
         return 3'($urandom_range(5, 7));
      return mm2_pkg::FULL_COUNT;
   endfunction

   // one message: full words then a final word, sometimes left open
   task send_message();
      int          n_full;
      int          i;
      logic [2:0]  c;
      bit          last_flag;
      logic [31:0] length;
      n_full = ($urandom_range(9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
      c = 3'($urandom_range(0, 4));
      last_flag = (c == mm2_pkg::FULL_COUNT) ? ($urandom_range(9) != 0)
                                             : 1'($urandom_range(0, 1));
      length = ($urandom_range(6) == 0) ? $urandom : 32'(n_full * 4 + c);
      for (i = 0; i <= n_full; i++) begin
         if (i < n_full)
            send_word(rand_word(), full_count(), i == 0, 1'b0,
                      (i == 0) ? length : $urandom);
         else
            send_word(rand_word(), (c == mm2_pkg::FULL_COUNT) ? full_count() : c,
                      i == 0, last_flag, (i == 0) ? length : $urandom);
      end
   endtask

   // close any open message, let every hash come out, then let the block settle
   task settle();
      if (sb.open)
         send_word($urandom, 3'd0, 1'b0, 1'b1, $urandom);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (12) @(posedge clock);
   endtask

   task write_seed(logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_seed(value);
   endtask

   // random phase: mostly well-formed messages, some stray words
   task run_phase(int phase, int target);
      int  start;
      bit  paused;
      start  = words_used;
      paused = 1'b0;
      if (phase == 0)
         hold_asks++;
      while (words_used - start < target) begin
         if ($urandom_range(11) == 0)
            send_word(rand_word(), 3'($urandom_range(0, 7)), 1'b0,
                      1'($urandom_range(0, 1)), $urandom);
         else
            send_message();
         // sender waits for every owed hash once
         if (phase == 1 && !paused && words_used - start >= target / 2) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
         end
      end
   endtask

   initial begin
      int          p;
      int          idle_by_phase[4];
      int          stall_by_phase[4];
      logic [31:0] seed_by_phase[4];
      idle_by_phase  = '{0, 80, 0, 18};
      stall_by_phase = '{0, 0, 80, 18};
      seed_by_phase  = '{32'hFFFF_FFFF, $urandom, 32'h0000_0001, $urandom};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_seed(32'h0000_0000);

      // directed: empty, single-word, tails, short without last, stray,
      // oversized counts, restart, unused bytes, length mismatch
      send_word(32'h1234_5678, 3'd0, 1'b1, 1'b1, 32'd0);
      send_word(32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, 32'd4);
      send_word(32'hFFFF_FFAB, 3'd1, 1'b1, 1'b1, 32'd1);
      send_word(32'hFFFF_FFFF, 3'd2, 1'b1, 1'b0, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFF, 3'd3, 1'b1, 1'b1, 32'd3);
      send_word(32'hDEAD_BEEF, 3'd4, 1'b0, 1'b1, 32'hFFFF_FFFF);
      send_word(32'h0000_0000, 3'd7, 1'b1, 1'b0, 32'd12);
      send_word(32'hFFFF_FFFF, 3'd5, 1'b0, 1'b0, 32'd0);
      send_word(32'hA5A5_5A5A, 3'd6, 1'b0, 1'b1, 32'd0);
      send_word(32'h0102_0304, 3'd4, 1'b1, 1'b0, 32'd8);
      send_word(32'h0506_0708, 3'd4, 1'b1, 1'b0, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFF, 3'd3, 1'b0, 1'b1, 32'd0);
      send_word(32'h0000_0000, 3'd4, 1'b1, 1'b0, 32'd12);
      send_word(32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 32'h8000_0000);
      send_word(32'h7FFF_FFFF, 3'd0, 1'b0, 1'b1, 32'd0);
      send_word(32'hFFFF_1234, 3'd2, 1'b1, 1'b1, 32'd7);
      send_word(32'h8000_0001, 3'd4, 1'b1, 1'b1, 32'h7FFF_FFFF);
      settle();

      for (p = 0; p < 4; p++) begin
         write_seed(seed_by_phase[p]);
         send_idle_pct = idle_by_phase[p];
         stall_pct     = stall_by_phase[p];
         run_phase(p, 138);
         settle();
      end

      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (20) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
src/mm2_pkg.sv
src/mm2_seq.sv
src/mm2_datapath.sv
src/murmur2_stream_hash_top.sv
dv/testbench.sv
